[rtl/tensor_element_to_fp32_converter_defines.svh]
// Assertion macros for the tensor element converter.
// No dependencies; included by the top level.
`ifndef TENSOR_ELEMENT_TO_FP32_CONVERTER_DEFINES_SVH
`define TENSOR_ELEMENT_TO_FP32_CONVERTER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define TEC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define TEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/tec_pkg.sv]
// Package for the tensor element converter: type codes and the conversion result type.
// No dependencies.
package tec_pkg;

  typedef enum logic [7:0] {
    TYPE_F32  = 8'd0,
    TYPE_F16  = 8'd1,
    TYPE_BF16 = 8'd2,
    TYPE_I8   = 8'd6,
    TYPE_U8   = 8'd7
  } elem_type_e;

  typedef struct packed {
    logic [31:0] bits;
    logic        bad;
  } conv_result_t;

endpackage

[rtl/tec_convert.sv]
// Combinational conversion of one raw element to single-precision bits.
// Depends on tec_pkg.
module tec_convert
  import tec_pkg::*;
(
  input  logic [7:0]   elem_type_i,
  input  logic [31:0]  raw_i,
  output conv_result_t res_o
);

  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  h_lz;       // shift to normalize an F16 subnormal
  logic [10:0] h_norm;
  logic [31:0] half_bits;

  logic [7:0]  b;
  logic        b_neg;
  logic [7:0]  mag;
  logic [2:0]  msb;
  logic [7:0]  mag_sh;
  logic [31:0] int_bits;

  // F16 widening
  always_comb begin
    h_sign = raw_i[15];
    h_exp  = raw_i[14:10];
    h_man  = raw_i[9:0];
    h_lz   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) h_lz = 4'(10 - i);
    end
    h_norm = {1'b0, h_man} << h_lz;
    if (h_exp == 5'd0) begin
      if (h_man == 10'd0) half_bits = {h_sign, 31'd0};
      else half_bits = {h_sign, 8'(8'd113 - {4'd0, h_lz}), h_norm[9:0], 13'd0};
    end else if (h_exp == 5'h1F) begin
      half_bits = {h_sign, 8'hFF, h_man, 13'd0};
    end else begin
      half_bits = {h_sign, 8'({3'd0, h_exp} + 8'd112), h_man, 13'd0};
    end
  end

  // byte to single: magnitude, leading one, normalize
  always_comb begin
    b     = raw_i[7:0];
    b_neg = (elem_type_i == TYPE_I8) && b[7];
    mag   = b_neg ? 8'(~b + 8'd1) : b;
    msb   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) msb = 3'(i);
    end
    mag_sh = mag << (3'd7 - msb);
    if (mag == 8'd0) int_bits = 32'd0;
    else int_bits = {b_neg, 8'(8'd127 + {5'd0, msb}), mag_sh[6:0], 16'd0};
  end

  // select by type
  always_comb begin
    res_o.bad = 1'b0;
    case (elem_type_i)
      TYPE_F32:  res_o.bits = raw_i;
      TYPE_F16:  res_o.bits = half_bits;
      TYPE_BF16: res_o.bits = {raw_i[15:0], 16'd0};
      TYPE_I8:   res_o.bits = int_bits;
      TYPE_U8:   res_o.bits = int_bits;
      default: begin
        res_o.bits = 32'd0;
        res_o.bad  = 1'b1;
      end
    endcase
  end

endmodule

[rtl/tensor_element_to_fp32_converter.sv]
// Top level of the tensor element converter: input register, conversion, output register.
// Depends on tec_pkg, tec_convert and the assertion macro header.
//
//  channel | valid / ready              | payload
//  in      | in_valid_i / in_ready_o    | raw_element_i
//  out     | out_valid_o / out_ready_i  | single_bits_o, unsupported_o
//  cfg     | cfg_we_i (no wait)         | cfg_wdata_i -> element_type
//
// Data passes raw_q then res_q; one item per cycle sustained unless the output stalls.
// Input and result stages each hold one item; an output stall backs up stage by stage.
// Reset clears both stage valids and sets element_type to F32.
`include "tensor_element_to_fp32_converter_defines.svh"
module tensor_element_to_fp32_converter
  import tec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] raw_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] single_bits_o,
  output logic        unsupported_o
);

  logic [7:0]   type_q;
  logic         s1_vld_q, s2_vld_q;
  logic [31:0]  raw_q;
  conv_result_t res_d, res_q;
  logic         s2_en, s1_en;

  assign s2_en      = !s2_vld_q || out_ready_i;
  assign s1_en      = !s1_vld_q || s2_en;
  assign in_ready_o = s1_en;

  tec_convert u_conv (
    .elem_type_i (type_q),
    .raw_i       (raw_q),
    .res_o       (res_d)
  );

  // configuration and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= 8'd0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) type_q <= cfg_wdata_i;
      if (s1_en) s1_vld_q <= in_valid_i;
      if (s2_en) s2_vld_q <= s1_vld_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) raw_q <= raw_element_i;
    if (s2_en && s1_vld_q) res_q <= res_d;
  end

  assign out_valid_o   = s2_vld_q;
  assign single_bits_o = res_q.bits;
  assign unsupported_o = res_q.bad;

  `TEC_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(single_bits_o))
  `TEC_ASSERT_IMP(a_bad_zero, out_valid_o && unsupported_o, single_bits_o == 32'd0)
  `TEC_ASSERT_IMP(a_full_blocks, s1_vld_q && s2_vld_q && !out_ready_i, !in_ready_o)

endmodule

[bench/testbench.sv]
// Testbench for the tensor element to single-precision converter.
// Depends on tec_pkg and the tensor_element_to_fp32_converter RTL.
`timescale 1ns / 1ps

module testbench;
  import tec_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] raw_element_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] single_bits_o;
  logic        unsupported_o;

  tensor_element_to_fp32_converter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .raw_element_i(raw_element_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .single_bits_o(single_bits_o), .unsupported_o(unsupported_o)
  );

  logic [7:0]  elem_type_q = TYPE_F32;  // predictor copy of the register
  logic [31:0] pending_raw[$];
  conv_result_t expected_conv[$];
  logic        calm = 1'b0;     // no idling stretch
  logic        hold_off = 1'b0; // long receiver stall request
  logic        in_taken = 1'b0; // input transfer at the last rising edge
  int          mismatches = 0;
  int          converted = 0;
  int          cycles = 0;
  int          type_uses[8];

  initial forever #6 clk_i = ~clk_i;

  // Exact byte magnitude to single precision
  function automatic logic [31:0] byte_to_single(logic [8:0] mag, logic neg);
    int          p;
    logic [31:0] w;
    if (mag == 0) return 32'd0;
    p = 8;
    while (p > 0 && !mag[p]) p--;
    w = {23'd0, mag} << (23 - p);
    return {neg, 8'(127 + p), w[22:0]};
  endfunction

  // Half precision widening with subnormal normalization
  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [10:0] m;
    int          s;
    m = {1'b0, h[9:0]};
    s = 0;
    if (h[14:10] == 5'd0) begin
      if (m == 0) return {h[15], 31'd0};
      while (!m[10] && s < 11) begin
        m = m << 1;
        s++;
      end
      return {h[15], 8'(113 - s), m[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
  endfunction

  function automatic conv_result_t convert_element(logic [7:0] t, logic [31:0] raw);
    conv_result_t r;
    r.bad = 1'b0;
    case (t)
      TYPE_F32:  r.bits = raw;
      TYPE_F16:  r.bits = half_to_single(raw[15:0]);
      TYPE_BF16: r.bits = {raw[15:0], 16'd0};
      TYPE_I8:   r.bits = raw[7] ? byte_to_single(9'h100 - raw[7:0], 1'b1)
                                 : byte_to_single({1'b0, raw[7:0]}, 1'b0);
      TYPE_U8:   r.bits = byte_to_single({1'b0, raw[7:0]}, 1'b0);
      default: begin
        r.bits = 32'd0;
        r.bad = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Driver: offer queued elements, idle at random, and drive the receiver ready at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold payload
      end else if (pending_raw.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        in_valid_i <= 1'b1;
        raw_element_i <= pending_raw[0];
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= !hold_off && (calm || $urandom_range(99) >= 36);
    end
  end

  // Monitor: record input transfers, compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    conv_result_t e;
    int           slot;
    cycles <= cycles + 1;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      converted <= converted + 1;
      if (expected_conv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", single_bits_o);
      end else begin
        e = expected_conv.pop_front();
        if (e.bits !== single_bits_o || e.bad !== unsupported_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b got %h/%b", e.bits, e.bad,
                     single_bits_o, unsupported_o);
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_conv.push_back(convert_element(elem_type_q, raw_element_i));
      case (elem_type_q)
        TYPE_F32, TYPE_F16, TYPE_BF16, TYPE_I8, TYPE_U8: slot = int'(elem_type_q);
        default: slot = 3;
      endcase
      type_uses[slot]++;
      void'(pending_raw.pop_front());
    end
    if (cycles > 400000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Wait until all offered elements have transferred and their results arrived
  task automatic drain();
    while (pending_raw.size() > 0 || expected_conv.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_type(logic [7:0] t);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= t;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    elem_type_q = t;
  endtask

  function automatic logic [31:0] random_element(logic [7:0] t);
    logic [31:0] r;
    r = $urandom;
    if (t == TYPE_F16 && $urandom_range(3) == 0)
      r[14:10] = $urandom_range(1) ? 5'h00 : 5'h1F;
    if (t == TYPE_F16 && $urandom_range(7) == 0) r[9:0] = 10'd0;
    return r;
  endfunction

  localparam logic [7:0] TypeOdd = 8'd3;
  localparam logic [7:0] TypeTop = 8'hFF;

  initial begin
    logic [7:0] types[8];
    logic [7:0] t;
    int         k;
    types = '{TYPE_F32, TYPE_F16, TYPE_BF16, TYPE_I8, TYPE_U8, TypeOdd, TypeTop, 8'd8};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset type F32, then each type with its edge cases, then one unsupported code
    pending_raw = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000};
    drain();
    set_type(TYPE_F16);
    pending_raw = '{32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03FF,
                    32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'h0000_3C00,
                    32'h0000_7BFF};
    drain();
    set_type(TYPE_BF16);
    pending_raw = '{32'hABCD_FFFF, 32'h0};
    drain();
    set_type(TYPE_I8);
    pending_raw = '{32'hFFFF_FF80, 32'h7F, 32'h0, 32'hFF, 32'h01};
    drain();
    set_type(TYPE_U8);
    pending_raw = '{32'hFFFF_FF00, 32'hFF, 32'h80};
    drain();
    set_type(TypeTop);
    pending_raw = '{32'h1234_5678};
    drain();

    // Random phases across listed and random type codes; one phase runs with a long output stall
    for (k = 0; k < 22; k++) begin
      t = ($urandom_range(9) == 0) ? 8'($urandom) : types[$urandom_range(7)];
      set_type(t);
      calm = (k == 5);
      repeat (50) pending_raw.push_back(random_element(t));
      if (k == 9) begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end
    calm = 1'b0;

    $display("converted %0d elements: f32 %0d f16 %0d bf16 %0d i8 %0d u8 %0d other %0d",
             converted, type_uses[0], type_uses[1], type_uses[2], type_uses[6],
             type_uses[7], type_uses[3]);
    if (mismatches == 0 && expected_conv.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
